### design/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and codes for the chained hash element store.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_WRITE  = 2'd2;
  localparam logic [1:0] ACT_ERASE  = 2'd3;

  localparam logic [31:0] MULT_RESET = 32'd1540483477;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] row_index;
    logic [15:0] col_index;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        created;
    logic [31:0] element_value;
    logic        status;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_HASH,
    CMD_HEAD,
    CMD_NODE_RD,
    CMD_STEP,
    CMD_HIT_RW,
    CMD_UNLINK,
    CMD_RELEASE,
    CMD_FREE_RD,
    CMD_ALLOC_FREE,
    CMD_ALLOC_FRESH,
    CMD_FULL
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       cur_ok;
    logic       key_match;
    logic       free_ok;
    logic       fresh_ok;
    logic       clr_last;
  } dp_status_t;

endpackage

### design/chs_datapath.sv
// ----------------------------------------------------------------------------
// chs_datapath
// Bucket head table, node pool memories, free list and chain walk registers.
// ----------------------------------------------------------------------------
module chs_datapath #(
  parameter int BUCKETS    = 256,
  parameter int NODES      = 1024,
  parameter int INDEX_BITS = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chs_pkg::cmd_t       cmd,
  input  chs_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  output chs_pkg::dp_status_t st,
  output chs_pkg::out_item_t  out_data
);

  localparam int HB = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NB = $clog2(NODES + 1);
  localparam int NA = $clog2(NODES);
  localparam int KW = 2 * INDEX_BITS;
  localparam int VW = VALUE_BITS;

  logic [NB-1:0] head_mem [BUCKETS];
  logic [NB-1:0] next_mem [NODES];
  logic [KW-1:0] key_mem  [NODES];
  logic [VW-1:0] data_mem [NODES];

  logic [1:0]    act_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] wval_r;
  logic [31:0]   col_r;
  logic [31:0]   prod_r;
  logic [31:0]   mult_r;
  logic [HB-1:0] bucket_r;
  logic [NB-1:0] head_q;
  logic [NB-1:0] cur_r, prev_r, steps_r;
  logic [NB-1:0] nxt_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] data_q;
  logic [NB-1:0] free_r, fresh_r;
  logic [HB-1:0] clr_r;
  logic          found_r, created_r, status_r;
  logic [VW-1:0] value_r;

  logic [INDEX_BITS-1:0] row_k, col_k;
  logic [31:0]   hash;
  logic [HB-1:0] bucket_calc;
  logic [NB-1:0] alloc_n;
  logic          is_alloc;
  logic [VW-1:0] alloc_val;

  logic          head_we;
  logic [HB-1:0] head_wa;
  logic [NB-1:0] head_wd;
  logic          next_we;
  logic [NA-1:0] next_wa;
  logic [NB-1:0] next_wd;
  logic          data_we;
  logic [NA-1:0] data_wa;
  logic [VW-1:0] data_wd;
  logic          node_rd;
  logic [NA-1:0] node_ra;

  assign row_k       = INDEX_BITS'(in_data.row_index);
  assign col_k       = INDEX_BITS'(in_data.col_index);
  assign hash        = prod_r + col_r;
  assign bucket_calc = HB'(hash) & HB'(BUCKETS - 1);
  assign is_alloc    = (cmd == chs_pkg::CMD_ALLOC_FREE) || (cmd == chs_pkg::CMD_ALLOC_FRESH);
  assign alloc_n     = (cmd == chs_pkg::CMD_ALLOC_FREE) ? free_r : fresh_r + NB'(1);
  assign alloc_val   = (act_r == chs_pkg::ACT_WRITE) ? wval_r : '0;

  assign st.act       = act_r;
  assign st.cur_ok    = (cur_r != '0) && (cur_r <= NB'(NODES)) && (steps_r < NB'(NODES));
  assign st.key_match = (key_q == key_r);
  assign st.free_ok   = (free_r != '0) && (free_r <= NB'(NODES));
  assign st.fresh_ok  = (fresh_r < NB'(NODES));
  assign st.clr_last  = (clr_r == HB'(BUCKETS - 1));

  assign out_data.found         = found_r;
  assign out_data.created       = created_r;
  assign out_data.element_value = 32'(value_r);
  assign out_data.status        = status_r;

  // write and read port steering
  always_comb begin
    head_we = 1'b0;
    head_wa = bucket_r;
    head_wd = alloc_n;
    next_we = 1'b0;
    next_wa = NA'(alloc_n - NB'(1));
    next_wd = head_q;
    data_we = 1'b0;
    data_wa = NA'(cur_r - NB'(1));
    data_wd = wval_r;
    node_rd = 1'b0;
    node_ra = NA'(cur_r - NB'(1));
    unique case (cmd)
      chs_pkg::CMD_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_r;
        head_wd = '0;
      end
      chs_pkg::CMD_NODE_RD: node_rd = 1'b1;
      chs_pkg::CMD_FREE_RD: begin
        node_rd = 1'b1;
        node_ra = NA'(free_r - NB'(1));
      end
      chs_pkg::CMD_HIT_RW: data_we = (act_r == chs_pkg::ACT_WRITE);
      chs_pkg::CMD_UNLINK: begin
        if (prev_r != '0) begin
          next_we = 1'b1;
          next_wa = NA'(prev_r - NB'(1));
          next_wd = nxt_q;
        end else begin
          head_we = 1'b1;
          head_wd = nxt_q;
        end
      end
      chs_pkg::CMD_RELEASE: begin
        next_we = 1'b1;
        next_wa = NA'(cur_r - NB'(1));
        next_wd = free_r;
      end
      chs_pkg::CMD_ALLOC_FREE, chs_pkg::CMD_ALLOC_FRESH: begin
        head_we = 1'b1;
        next_we = 1'b1;
        data_we = 1'b1;
        data_wa = NA'(alloc_n - NB'(1));
        data_wd = alloc_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd == chs_pkg::CMD_HASH) head_q <= head_mem[bucket_calc];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (data_we) data_mem[data_wa] <= data_wd;
    if (is_alloc) key_mem[NA'(alloc_n - NB'(1))] <= key_r;
    if (node_rd) begin
      nxt_q  <= next_mem[node_ra];
      key_q  <= key_mem[node_ra];
      data_q <= data_mem[node_ra];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '0;
      fresh_r <= '0;
      clr_r   <= '0;
      mult_r  <= chs_pkg::MULT_RESET;
    end else begin
      if (cfg_we) mult_r <= cfg_data;
      unique case (cmd)
        chs_pkg::CMD_CLEAR:       clr_r   <= clr_r + HB'(1);
        chs_pkg::CMD_RELEASE:     free_r  <= cur_r;
        chs_pkg::CMD_ALLOC_FREE:  free_r  <= nxt_q;
        chs_pkg::CMD_ALLOC_FRESH: fresh_r <= alloc_n;
        default: ;
      endcase
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      chs_pkg::CMD_LOAD: begin
        act_r     <= in_data.action;
        key_r     <= {row_k, col_k};
        wval_r    <= VW'(in_data.write_value);
        col_r     <= 32'(col_k);
        prod_r    <= 32'(row_k) * mult_r;
        found_r   <= 1'b0;
        created_r <= 1'b0;
        status_r  <= 1'b0;
        value_r   <= '0;
      end
      chs_pkg::CMD_HASH: bucket_r <= bucket_calc;
      chs_pkg::CMD_HEAD: begin
        cur_r   <= head_q;
        prev_r  <= '0;
        steps_r <= '0;
      end
      chs_pkg::CMD_STEP: begin
        prev_r  <= cur_r;
        cur_r   <= nxt_q;
        steps_r <= steps_r + NB'(1);
      end
      chs_pkg::CMD_HIT_RW: begin
        found_r <= 1'b1;
        value_r <= (act_r == chs_pkg::ACT_WRITE) ? wval_r : data_q;
      end
      chs_pkg::CMD_UNLINK: found_r <= 1'b1;
      chs_pkg::CMD_ALLOC_FREE, chs_pkg::CMD_ALLOC_FRESH: begin
        created_r <= 1'b1;
        value_r   <= alloc_val;
      end
      chs_pkg::CMD_FULL: status_r <= 1'b1;
      default: ;
    endcase
  end

endmodule

### design/chs_ctrl.sv
// ----------------------------------------------------------------------------
// chs_ctrl
// Sequencer for the hash, chain walk and update steps of one request.
// ----------------------------------------------------------------------------
module chs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  chs_pkg::dp_status_t st,
  output chs_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_WALK, S_CMP, S_HIT, S_FREE,
    S_MISS, S_ALLOC_F, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   take;

  assign out_valid = out_valid_r;
  assign in_stall  = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign take      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = chs_pkg::CMD_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd = chs_pkg::CMD_CLEAR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cmd       = chs_pkg::CMD_LOAD;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd       = chs_pkg::CMD_HASH;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd       = chs_pkg::CMD_HEAD;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (st.cur_ok) begin
          cmd       = chs_pkg::CMD_NODE_RD;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_CMP: begin
        if (st.key_match) begin
          state_nxt = S_HIT;
        end else begin
          cmd       = chs_pkg::CMD_STEP;
          state_nxt = S_WALK;
        end
      end
      S_HIT: begin
        if (st.act == chs_pkg::ACT_ERASE) begin
          cmd       = chs_pkg::CMD_UNLINK;
          state_nxt = S_FREE;
        end else begin
          cmd       = chs_pkg::CMD_HIT_RW;
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        cmd       = chs_pkg::CMD_RELEASE;
        state_nxt = S_DONE;
      end
      S_MISS: begin
        state_nxt = S_DONE;
        if (st.act == chs_pkg::ACT_CREATE || st.act == chs_pkg::ACT_WRITE) begin
          priority if (st.free_ok) begin
            cmd       = chs_pkg::CMD_FREE_RD;
            state_nxt = S_ALLOC_F;
          end else if (st.fresh_ok) begin
            cmd = chs_pkg::CMD_ALLOC_FRESH;
          end else begin
            cmd = chs_pkg::CMD_FULL;
          end
        end
      end
      S_ALLOC_F: begin
        cmd       = chs_pkg::CMD_ALLOC_FREE;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule

### design/chained_hash_element_store.sv
// ----------------------------------------------------------------------------
// chained_hash_element_store
// Sparse 2-D element store: hashed buckets, chained nodes and a free list.
// ----------------------------------------------------------------------------
// One request at a time. A request passes S_HASH and S_HEAD, then S_WALK
// and S_CMP for each chain node visited (each visit is a registered read
// of the single-port node pool then a key compare); a hit goes on to S_HIT
// and a miss to S_MISS, both then to S_DONE. Erase of a present key adds
// S_FREE and allocation from the free list adds S_ALLOC_F. The next request
// is taken once the result has been accepted. After reset a clearing pass
// over all BUCKETS heads zeroes them before the first request is taken; the
// multiplier register may be written throughout (cfg_ready is always high).
module chained_hash_element_store #(
  parameter int BUCKETS    = 256,
  parameter int NODES      = 1024,
  parameter int INDEX_BITS = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output chs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  chs_pkg::cmd_t       cmd;
  chs_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  chs_datapath #(
    .BUCKETS    (BUCKETS),
    .NODES      (NODES),
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .st       (st),
    .out_data (out_data)
  );

endmodule

### design/chs_checker.sv
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks for the chained hash element store.
// ----------------------------------------------------------------------------
module chs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input chs_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_found_created: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.created))
    else $error("found and created together");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      !out_data.found && !out_data.created && out_data.element_value == 32'd0)
    else $error("refused insert reported a node");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown straight after acceptance");

endmodule

bind chained_hash_element_store chs_checker u_chs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### test/tb_chained_hash_element_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chained_hash_element_store
// Regression for the chained hash element store. A scoreboard keeps its own
// bucket table, node pool and free list. It predicts every request and
// checks each result in order. Directed cases come first: chain collisions,
// erase in mid chain and free-list reuse. Random requests follow under
// several hash multipliers, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_chained_hash_element_store;

  localparam int NUM_BUCKETS = 256;
  localparam int NUM_NODES   = 1024;
  localparam int IDLE_LIMIT  = 20000;

  class element_scoreboard;
    logic [31:0]  mult;
    logic [10:0]  head_tab [NUM_BUCKETS];
    logic [10:0]  link_tab [NUM_NODES];
    logic [31:0]  key_tab  [NUM_NODES];
    logic [31:0]  data_tab [NUM_NODES];
    logic [10:0]  free_top;
    int           fresh_used;
    int           live_nodes;
    chs_pkg::out_item_t expected_q [$];
    int           errors;

    function new();
      mult = chs_pkg::MULT_RESET;
      foreach (head_tab[i]) head_tab[i] = '0;
      free_top   = '0;
      fresh_used = 0;
      live_nodes = 0;
      errors     = 0;
    endfunction

    function void note_request(chs_pkg::in_item_t req);
      chs_pkg::out_item_t res;
      logic [31:0] key;
      logic [31:0] h;
      logic [7:0]  bkt;
      int          cur;
      int          prev;
      int          steps;
      int          n;
      res   = '0;
      key   = {req.row_index, req.col_index};
      h     = 32'(req.row_index) * mult + 32'(req.col_index);
      bkt   = h[7:0];
      cur   = head_tab[bkt];
      prev  = 0;
      steps = 0;
      while (cur >= 1 && cur <= NUM_NODES && steps < NUM_NODES) begin
        if (key_tab[cur-1] == key) break;
        prev = cur;
        cur  = link_tab[cur-1];
        steps++;
      end
      if (!(cur >= 1 && cur <= NUM_NODES && steps < NUM_NODES)) cur = 0;
      if (cur != 0) begin
        res.found = 1'b1;
        if (req.action == chs_pkg::ACT_ERASE) begin
          if (prev != 0) link_tab[prev-1] = link_tab[cur-1];
          else head_tab[bkt] = link_tab[cur-1];
          link_tab[cur-1] = free_top;
          free_top = 11'(cur);
          if (live_nodes > 0) live_nodes--;
        end else begin
          if (req.action == chs_pkg::ACT_WRITE) data_tab[cur-1] = req.write_value;
          res.element_value = data_tab[cur-1];
        end
      end else if (req.action == chs_pkg::ACT_CREATE || req.action == chs_pkg::ACT_WRITE) begin
        n = 0;
        if (free_top >= 1 && free_top <= NUM_NODES) begin
          n = free_top;
          free_top = link_tab[n-1];
        end else if (fresh_used < NUM_NODES) begin
          fresh_used++;
          n = fresh_used;
        end
        if (n == 0) begin
          res.status = 1'b1;
        end else begin
          key_tab[n-1]  = key;
          data_tab[n-1] = (req.action == chs_pkg::ACT_WRITE) ? req.write_value : 32'd0;
          link_tab[n-1] = head_tab[bkt];
          head_tab[bkt] = 11'(n);
          live_nodes++;
          res.created       = 1'b1;
          res.element_value = data_tab[n-1];
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(chs_pkg::out_item_t got);
      chs_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  chs_pkg::in_item_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  chs_pkg::out_item_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [31:0] cfg_data = '0;

  element_scoreboard sb = new();
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  chained_hash_element_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // gap cycles with valid low, then hold the request until taken
  task automatic send_request(chs_pkg::in_item_t req, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic send_rand_gap(logic [1:0] act, logic [15:0] row, logic [15:0] col,
                               logic [31:0] val);
    send_request('{action: act, row_index: row, col_index: col, write_value: val},
                 $urandom_range(0, 5));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_multiplier(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.mult = v;
  endtask

  function automatic chs_pkg::in_item_t random_request();
    chs_pkg::in_item_t r;
    r.action = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 7) begin
      r.row_index = 16'($urandom_range(0, 7));
      r.col_index = 16'($urandom_range(0, 7));
    end else begin
      r.row_index = 16'($urandom);
      r.col_index = 16'($urandom);
    end
    case ($urandom_range(0, 5))
      0: r.write_value = '0;
      1: r.write_value = '1;
      default: r.write_value = $urandom;
    endcase
    return r;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_request(random_request(), $urandom_range(0, 5));
  endtask

  // result side
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        k = 300;
      end else begin
        k = $urandom_range(0, 5);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  // no progress for too long: give up
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("chained_hash_element_store regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty lookups, extremes, collisions in one bucket
    send_rand_gap(chs_pkg::ACT_LOOKUP, 16'h0000, 16'h0000, 32'h0);
    send_rand_gap(chs_pkg::ACT_ERASE,  16'h0000, 16'h0000, 32'h0);
    send_rand_gap(chs_pkg::ACT_WRITE,  16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_rand_gap(chs_pkg::ACT_LOOKUP, 16'h0000, 16'h0000, 32'h0);
    send_rand_gap(chs_pkg::ACT_CREATE, 16'h0000, 16'h0000, 32'h1234_5678);
    send_rand_gap(chs_pkg::ACT_CREATE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_rand_gap(chs_pkg::ACT_WRITE,  16'hFFFF, 16'hFFFF, 32'h0);
    send_rand_gap(chs_pkg::ACT_LOOKUP, 16'hFFFF, 16'hFFFF, 32'h0);
    // with row 0 the hash is the column, so these share bucket 5
    send_rand_gap(chs_pkg::ACT_WRITE,  16'h0000, 16'h0005, 32'hA5A5_A5A5);
    send_rand_gap(chs_pkg::ACT_WRITE,  16'h0000, 16'h0105, 32'h5A5A_5A5A);
    send_rand_gap(chs_pkg::ACT_WRITE,  16'h0000, 16'h0205, 32'h0F0F_0F0F);
    send_rand_gap(chs_pkg::ACT_ERASE,  16'h0000, 16'h0105, 32'h0);
    send_rand_gap(chs_pkg::ACT_LOOKUP, 16'h0000, 16'h0005, 32'h0);
    send_rand_gap(chs_pkg::ACT_LOOKUP, 16'h0000, 16'h0205, 32'h0);
    send_rand_gap(chs_pkg::ACT_LOOKUP, 16'h0000, 16'h0105, 32'h0);
    send_rand_gap(chs_pkg::ACT_ERASE,  16'h0000, 16'h0205, 32'h0);
    send_rand_gap(chs_pkg::ACT_ERASE,  16'h0000, 16'h0005, 32'h0);
    // free-list reuse
    send_rand_gap(chs_pkg::ACT_CREATE, 16'h1234, 16'h00FF, 32'h0);
    send_rand_gap(chs_pkg::ACT_WRITE,  16'h8000, 16'h0001, 32'h8000_0001);
    send_rand_gap(chs_pkg::ACT_LOOKUP, 16'h8000, 16'h0001, 32'h0);

    // long receiver hold while requests keep coming
    hold_req = 1'b1;
    random_phase(120);
    // sender waits for every result before going on
    drain();
    random_phase(100);

    // multiplier change with nodes live
    write_multiplier(32'h0000_0000);
    random_phase(80);

    // burst of new nodes, then erase most of them
    write_multiplier(chs_pkg::MULT_RESET);
    for (int i = 0; i < 60; i++)
      send_request('{action: chs_pkg::ACT_CREATE, row_index: 16'(i * 7 + 300),
                     col_index: 16'(i), write_value: 32'h0}, $urandom_range(0, 5));
    send_rand_gap(chs_pkg::ACT_WRITE, 16'hFFFE, 16'h0003, 32'hDEAD_BEEF);
    for (int i = 0; i < 40; i++)
      send_request('{action: chs_pkg::ACT_ERASE, row_index: 16'(i * 7 + 300),
                     col_index: 16'(i), write_value: 32'h0}, $urandom_range(0, 5));

    write_multiplier(32'hFFFF_FFFF);
    random_phase(70);
    write_multiplier($urandom);
    hold_req = 1'b1;
    random_phase(60);

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("chained_hash_element_store regression: pass");
    else
      $display("chained_hash_element_store regression: fail");
    $finish;
  end

endmodule
